/* hdl/dts_pkg.sv */
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the topological sort unit
// Word layouts for the input and result channels, command codes and the
// default sizes of the graph store.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  // Fixed field widths of the channel words.
  localparam int VERTEX_W = 6;

  // Default sizes of the graph store.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  // Command codes carried in the func field.
  localparam logic FUNC_ADD_EDGE = 1'b0;
  localparam logic FUNC_SORT     = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // One input word.
  typedef struct packed {
    logic                func;
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
    logic                status;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/dfs_topological_sort_unit.sv */
// ----------------------------------------------------------------------------
// dfs_topological_sort_unit: depth-first topological sort engine
// Builds per-vertex adjacency lists one edge at a time and, on request, walks
// depth first from a start vertex and streams the reachable vertices out in
// reverse finishing order.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_ready  | func, src_vertex, dst_vertex
//   out_    | output    | out_valid/out_ready| vertex, last, status
//
// An edge add reads the list head, then writes the link; a dropped edge or an
// out-of-range start loads its result in the accept cycle.
// A sort takes per visited vertex one list head read, one edge read per
// adjacency entry scanned (the scan restarts at the list head after each
// return), and one stack read on return; each result is then read from the
// finish order memory. The adjacency memory read port sets the walk rate.
// Input is taken only when the engine is idle and the output register is free
// or being emptied. A stalled output holds the engine in place.
// Reset is synchronous; it empties the graph through per-vertex head valid
// bits, so no clearing pass runs.
`default_nettype none

module dfs_topological_sort_unit #(
  parameter int MaxVertices = dts_pkg::MAX_VERTICES_DEF,
  parameter int MaxEdges    = dts_pkg::MAX_EDGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dts_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dts_pkg::out_word_t      out_data
);

  import dts_pkg::*;

  // Derived widths.
  localparam int VW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int DW  = $clog2(MaxVertices + 1);
  localparam int EW  = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int ECW = $clog2(MaxEdges + 1);
  localparam int EGW = 1 + EW + VW;

  // Engine states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EWR  = 3'd6;

  // Control registers.
  logic [2:0]             state_r, state_nxt;
  logic [VW-1:0]          top_r, top_nxt;
  logic [VW-1:0]          dst_r, dst_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [DW-1:0]          fc_r, fc_nxt;
  logic [ECW-1:0]         ec_r, ec_nxt;
  logic [VW-1:0]          idx_r, idx_nxt;
  logic [MaxVertices-1:0] vis_r, vis_nxt;
  logic [MaxVertices-1:0] head_vld_r;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  // Memories.
  logic [EW-1:0]  head_mem [MaxVertices];
  logic [EGW-1:0] edge_mem [MaxEdges];
  logic [VW-1:0]  stk_mem  [MaxVertices];
  logic [VW-1:0]  fin_mem  [MaxVertices];

  // Memory ports.
  logic           hd_re, hd_we;
  logic [VW-1:0]  hd_raddr;
  logic [EW-1:0]  hd_rdata;
  logic           hv_q;
  logic           eg_re, eg_we;
  logic [EW-1:0]  eg_raddr;
  logic [EGW-1:0] eg_wdata, eg_rdata;
  logic           st_re, st_we;
  logic [VW-1:0]  st_raddr, st_waddr, st_rdata;
  logic           fn_re, fn_we;
  logic [VW-1:0]  fn_rdata;

  // Helpers.
  logic           out_free;
  logic           in_fire;
  logic           do_finish;
  logic [DW-1:0]  dm1, dm2;
  logic [VW-1:0]  eg_target;
  logic [EW-1:0]  eg_next;
  logic           eg_next_vld;
  logic           src_bad, dst_bad;
  logic [VW-1:0]  in_src, in_dst;

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign dm1         = depth_r - DW'(1);
  assign dm2         = depth_r - DW'(2);
  assign eg_target   = eg_rdata[VW-1:0];
  assign eg_next     = eg_rdata[VW+EW-1:VW];
  assign eg_next_vld = eg_rdata[EGW-1];

  assign src_bad = {1'b0, in_data.src_vertex} >= (VERTEX_W+1)'(MaxVertices);
  assign dst_bad = {1'b0, in_data.dst_vertex} >= (VERTEX_W+1)'(MaxVertices);
  assign in_src  = VW'(in_data.src_vertex);
  assign in_dst  = VW'(in_data.dst_vertex);

  // Next-state logic of the walk engine.
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    dst_nxt       = dst_r;
    depth_nxt     = depth_r;
    fc_nxt        = fc_r;
    ec_nxt        = ec_r;
    idx_nxt       = idx_r;
    vis_nxt       = vis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    hd_re         = 1'b0;
    hd_raddr      = top_r;
    hd_we         = 1'b0;
    eg_re         = 1'b0;
    eg_raddr      = hd_rdata;
    eg_we         = 1'b0;
    eg_wdata      = {hv_q, hd_rdata, dst_r};
    st_re         = 1'b0;
    st_raddr      = dm2[VW-1:0];
    st_we         = 1'b0;
    st_waddr      = dm1[VW-1:0];
    fn_re         = 1'b0;
    fn_we         = 1'b0;
    do_finish     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.func == FUNC_ADD_EDGE) begin
            if (ec_r >= ECW'(MaxEdges) || src_bad || dst_bad) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{vertex: '0, last: 1'b1, status: STATUS_DROPPED};
            end else begin
              hd_re     = 1'b1;
              hd_raddr  = in_src;
              top_nxt   = in_src;
              dst_nxt   = in_dst;
              state_nxt = S_EDGE;
            end
          end else begin
            if (src_bad) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{vertex: in_data.src_vertex, last: 1'b1,
                                status: STATUS_OK};
            end else begin
              vis_nxt         = '0;
              vis_nxt[in_src] = 1'b1;
              top_nxt         = in_src;
              depth_nxt       = DW'(1);
              fc_nxt          = '0;
              hd_re           = 1'b1;
              hd_raddr        = in_src;
              state_nxt       = S_HEAD;
            end
          end
        end
      end
      S_EDGE: begin
        // Link the new edge in front of the source's list.
        eg_we         = 1'b1;
        hd_we         = 1'b1;
        ec_nxt        = ec_r + ECW'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{vertex: '0, last: 1'b1, status: STATUS_OK};
        state_nxt     = S_IDLE;
      end
      S_HEAD: begin
        if (!hv_q) begin
          do_finish = 1'b1;
        end else begin
          eg_re     = 1'b1;
          eg_raddr  = hd_rdata;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!vis_r[eg_target] && depth_r < DW'(MaxVertices)) begin
          // Descend into the first unvisited neighbor.
          vis_nxt[eg_target] = 1'b1;
          st_we              = 1'b1;
          top_nxt            = eg_target;
          depth_nxt          = depth_r + DW'(1);
          hd_re              = 1'b1;
          hd_raddr           = eg_target;
          state_nxt          = S_HEAD;
        end else if (eg_next_vld) begin
          eg_re    = 1'b1;
          eg_raddr = eg_next;
        end else begin
          do_finish = 1'b1;
        end
      end
      S_POP: begin
        top_nxt   = st_rdata;
        hd_re     = 1'b1;
        hd_raddr  = st_rdata;
        state_nxt = S_HEAD;
      end
      S_ERD: begin
        fn_re     = 1'b1;
        state_nxt = S_EWR;
      end
      S_EWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{vertex: VERTEX_W'(fn_rdata), last: (idx_r == '0),
                            status: STATUS_OK};
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - VW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The top vertex has no unvisited neighbor: record it and return.
    if (do_finish) begin
      fn_we     = (fc_r < DW'(MaxVertices));
      fc_nxt    = fc_r + DW'(1);
      depth_nxt = depth_r - DW'(1);
      if (depth_r == DW'(1)) begin
        idx_nxt   = fc_r[VW-1:0];
        state_nxt = S_ERD;
      end else begin
        st_re     = 1'b1;
        state_nxt = S_POP;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      fc_r        <= '0;
      ec_r        <= '0;
      vis_r       <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      fc_r        <= fc_nxt;
      ec_r        <= ec_nxt;
      vis_r       <= vis_nxt;
      out_valid_r <= out_valid_nxt;
      if (hd_we) begin
        head_vld_r[top_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    dst_r      <= dst_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // List head memory with its valid bit read alongside.
  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[top_r] <= ec_r[EW-1:0];
    end
    if (hd_re) begin
      hd_rdata <= head_mem[hd_raddr];
      hv_q     <= head_vld_r[hd_raddr];
    end
  end

  // Edge memory: next link valid, next link, target.
  always_ff @(posedge clk) begin
    if (eg_we) begin
      edge_mem[ec_r[EW-1:0]] <= eg_wdata;
    end
    if (eg_re) begin
      eg_rdata <= edge_mem[eg_raddr];
    end
  end

  // Walk stack memory; the top entry lives in top_r.
  always_ff @(posedge clk) begin
    if (st_we) begin
      stk_mem[st_waddr] <= top_r;
    end
    if (st_re) begin
      st_rdata <= stk_mem[st_raddr];
    end
  end

  // Finish order memory.
  always_ff @(posedge clk) begin
    if (fn_we) begin
      fin_mem[fc_r[VW-1:0]] <= top_r;
    end
    if (fn_re) begin
      fn_rdata <= fin_mem[idx_r];
    end
  end

`ifndef NO_ASSERTIONS
  // The walk never holds more vertices than exist.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MaxVertices))
    else $error("walk stack depth exceeds vertex count");

  // While walking, the stack is not empty and its top is marked visited.
  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD || state_r == S_SCAN) |-> (depth_r != '0) && vis_r[top_r])
    else $error("walk top is not a visited vertex");

  // A stored edge advances the edge count by exactly one.
  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE) |=> (ec_r == $past(ec_r) + ECW'(1)))
    else $error("edge count did not advance on edge store");

  // A result is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EWR && out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending result overwritten during emit");
`endif

endmodule

`default_nettype wire
